// ===== hw/rtl/csvg_pkg.sv =====
// csvg_pkg: widths, register codes, cordic constants and the shared
// long-division step of the cone segment vertex generator.
// No dependencies; every other file of the block imports it.
package csvg_pkg;

	// field and register widths
	localparam int SEG_W       = 13;
	localparam int IDX_W       = 12;
	localparam int RAD_W       = 16;
	localparam int HGT_W       = 16;
	localparam int POS_W       = 17;
	localparam int TEXU_W      = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int DEF_MAX_SEGMENTS = 4096;
	localparam int QUEUE_DEPTH      = 4;

	// phase and texture quotients, worked out over a run of divider stages
	localparam int PHASE_W       = 32;
	localparam int FRAC_W        = 16;
	localparam int DIV_STAGES    = 8;
	localparam int P_STEPS_PER   = PHASE_W / DIV_STAGES;
	localparam int U_STEPS_PER   = FRAC_W / DIV_STAGES;

	// cordic in Q2.30 with head room
	localparam int CW             = 33;
	localparam int CORDIC_STEPS   = 16;
	localparam int CORDIC_STAGES  = 8;
	localparam int CORDIC_PER     = CORDIC_STEPS / CORDIC_STAGES;
	localparam int PROD_W         = 48;

	localparam logic signed [CW-1:0] GAIN_INV    = 33'sd652032874;
	localparam logic [30:0]          HALF_PI_Q30 = 31'd1686629713;
	localparam logic [15:0]          POS_LIMIT   = 16'd65535;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS   = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_SEGMENTS = 2'd2
	} cfg_reg_t;

	// settled configuration as the datapath sees it
	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [HGT_W:0]   half;
		logic [SEG_W-1:0] n;
	} csvg_cfg_t;

	typedef struct packed {
		logic [SEG_W-1:0] r;
		logic             q;
	} div_res_t;

	// one restoring division step, remainder stays below n
	function automatic div_res_t div_step(input logic [SEG_W-1:0] r, input logic b,
			input logic [SEG_W-1:0] n);
		div_res_t    res;
		logic [SEG_W:0] t;
		t = {r, b};
		if (t >= {1'b0, n}) begin
			res.q = 1'b1;
			res.r = SEG_W'(t - {1'b0, n});
		end else begin
			res.q = 1'b0;
			res.r = t[SEG_W-1:0];
		end
		return res;
	endfunction

	// arctangent of 2^-k in Q2.30
	function automatic logic signed [CW-1:0] atan_q30(input int k);
		logic signed [CW-1:0] a;
		case (k)
			0:  a = 33'sd843314857;
			1:  a = 33'sd497837830;
			2:  a = 33'sd263043837;
			3:  a = 33'sd133525159;
			4:  a = 33'sd67021687;
			5:  a = 33'sd33543516;
			6:  a = 33'sd16775850;
			7:  a = 33'sd8388437;
			8:  a = 33'sd4194283;
			9:  a = 33'sd2097149;
			10: a = 33'sd1048576;
			11: a = 33'sd524288;
			12: a = 33'sd262144;
			13: a = 33'sd131072;
			14: a = 33'sd65536;
			default: a = 33'sd32768;
		endcase
		return a;
	endfunction

endpackage

// ===== hw/rtl/csvg_if.sv =====
// csvg_if: valid/ready channels of the cone segment vertex generator,
// one for segment words in, one for vertex words out. Uses csvg_pkg.
interface csvg_seg_if import csvg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] segment_index;

	modport source(output valid, output segment_index, input ready);
	modport sink(input valid, input segment_index, output ready);
endinterface

interface csvg_vtx_if import csvg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic [TEXU_W-1:0]        tex_u;
	logic                     tex_v;
	logic                     last_vertex;

	modport source(output valid, output pos_x, output pos_y, output pos_z, output tex_u,
		output tex_v, output last_vertex, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z, input tex_u,
		input tex_v, input last_vertex, output ready);
endinterface

// ===== hw/rtl/csvg_front.sv =====
// csvg_front: takes segment words, clamps the index to the segment count
// and pushes it into the item queue. Uses csvg_pkg and csvg_if.
module csvg_front import csvg_pkg::*; (
	csvg_seg_if.sink          seg_in,
	input  csvg_cfg_t         cfg,
	input  logic              q_full,
	output logic              push,
	output logic [IDX_W-1:0]  push_idx
);

	// accept while the queue has room
	assign seg_in.ready = !q_full;
	assign push         = seg_in.valid && !q_full;

	// out of range index becomes the last segment
	always_comb begin
		if ({1'b0, seg_in.segment_index} >= cfg.n) begin
			push_idx = IDX_W'(cfg.n - 1'b1);
		end else begin
			push_idx = seg_in.segment_index;
		end
	end

endmodule

// ===== hw/rtl/csvg_queue.sv =====
// csvg_queue: short register fifo of clamped segment indices between
// front and back. Uses csvg_pkg for its default width and depth.
module csvg_queue import csvg_pkg::*; #(
	parameter int W     = IDX_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign valid = (cnt_q != '0);
	assign data  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/csvg_back.sv =====
// csvg_back: turns each queued segment into three vertex jobs and runs them
// through divider, cordic and scaling stages to the output register.
// Uses csvg_pkg and csvg_if.
module csvg_back import csvg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  csvg_cfg_t         cfg,
	input  logic              q_valid,
	input  logic [IDX_W-1:0]  q_idx,
	output logic              q_pop,
	csvg_vtx_if.source        vtx_out
);

	typedef enum logic [2:0] {
		SEQ_FIRST = 3'b001,
		SEQ_APEX  = 3'b010,
		SEQ_CLOSE = 3'b100
	} seq_t;

	typedef struct packed {
		logic                   apex;
		logic                   last;
		logic [SEG_W-1:0]       rp;
		logic [PHASE_W-1:0]     qp;
		logic [SEG_W-1:0]       ru;
		logic [FRAC_W-1:0]      qu;
		logic [FRAC_W-1:0]      fu;
		logic                   hi;
		logic signed [POS_W-1:0] py;
	} div_t;

	typedef struct packed {
		logic                    apex;
		logic                    last;
		logic [TEXU_W-1:0]       u;
		logic signed [POS_W-1:0] py;
	} tag_t;

	seq_t seq_q;
	logic en, issue;
	logic out_vld_q;

	// whole pipe advances unless a finished word waits
	assign en    = !out_vld_q || vtx_out.ready;
	assign issue = q_valid && en;
	assign q_pop = issue && (seq_q == SEQ_CLOSE);

	// three jobs per segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_FIRST;
		end else if (issue) begin
			case (seq_q)
				SEQ_FIRST: seq_q <= SEQ_APEX;
				SEQ_APEX:  seq_q <= SEQ_CLOSE;
				SEQ_CLOSE: seq_q <= SEQ_FIRST;
				default:   seq_q <= SEQ_FIRST;
			endcase
		end
	end

	// job set-up: start remainders, dividend tail and y
	logic [FRAC_W-1:0]  h16;
	logic [PHASE_W-1:0] pdiv;
	logic [SEG_W-1:0]   j, r0;
	logic               wrap;
	div_t               job;

	assign h16  = FRAC_W'(cfg.n >> 1);
	assign pdiv = PHASE_W'(h16);

	always_comb begin
		j    = (seq_q == SEQ_CLOSE) ? {1'b0, q_idx} + 1'b1 : {1'b0, q_idx};
		wrap = (j == cfg.n);
		r0   = wrap ? '0 : j;
		job.apex = (seq_q == SEQ_APEX);
		job.last = (seq_q == SEQ_CLOSE);
		job.rp   = r0;
		job.qp   = '0;
		job.qu   = '0;
		if (seq_q == SEQ_APEX) begin
			job.ru = {1'b0, q_idx};
			job.fu = 16'h8000 | h16;
			job.hi = 1'b0;
			job.py = $signed(cfg.half);
		end else begin
			job.ru = r0;
			job.fu = h16;
			job.hi = wrap;
			job.py = -$signed(cfg.half);
		end
	end

	// divider stages: phase and texture quotients bit by bit
	div_t               div_s  [DIV_STAGES+1];
	div_t               div_nx [DIV_STAGES];
	logic [DIV_STAGES:0] div_vld;

	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
		always_comb begin
			div_t     d;
			div_res_t res;
			d = div_s[s];
			for (int m = 0; m < P_STEPS_PER; m++) begin
				res  = div_step(d.rp, pdiv[PHASE_W-1-(s*P_STEPS_PER+m)], cfg.n);
				d.rp = res.r;
				d.qp = {d.qp[PHASE_W-2:0], res.q};
			end
			for (int m = 0; m < U_STEPS_PER; m++) begin
				res  = div_step(d.ru, d.fu[FRAC_W-1-(s*U_STEPS_PER+m)], cfg.n);
				d.ru = res.r;
				d.qu = {d.qu[FRAC_W-2:0], res.q};
			end
			div_nx[s] = d;
		end
	end

	// octant fold and scaling of the residual to radians
	div_t               dl;
	logic [29:0]        r30;
	logic               ph_neg;
	logic [1:0]         ph_quad;
	logic [30:0]        ph_mag;
	tag_t               ph_tag;

	assign dl = div_s[DIV_STAGES];

	always_comb begin
		r30     = dl.qp[29:0];
		ph_neg  = r30[29];
		ph_quad = dl.qp[31:30] + {1'b0, ph_neg};
		ph_mag  = ph_neg ? (31'h4000_0000 - {1'b0, r30}) : {1'b0, r30};
		ph_tag.apex = dl.apex;
		ph_tag.last = dl.last;
		ph_tag.u    = {dl.hi, dl.qu};
		ph_tag.py   = dl.py;
	end

	logic [60:0] ph_prod_s1;
	logic        ph_neg_s1;
	logic [1:0]  ph_quad_s1;
	tag_t        ph_tag_s1;
	logic        ph_vld_s1;

	// cordic start values
	logic [60:0]          zr;
	logic [30:0]          zmag;
	logic signed [CW-1:0] z_init;

	always_comb begin
		zr     = ph_prod_s1 + 61'h2000_0000;
		zmag   = zr[60:30];
		z_init = ph_neg_s1 ? -$signed({2'b00, zmag}) : $signed({2'b00, zmag});
	end

	// cordic stages
	logic signed [CW-1:0] cx_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] cy_s [CORDIC_STAGES+1];
	logic signed [CW-1:0] cz_s [CORDIC_STAGES+1];
	logic [1:0]           cq_s [CORDIC_STAGES+1];
	tag_t                 ct_s [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0] c_vld;
	logic signed [CW-1:0] nx_x [CORDIC_STAGES];
	logic signed [CW-1:0] nx_y [CORDIC_STAGES];
	logic signed [CW-1:0] nx_z [CORDIC_STAGES];

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		always_comb begin
			logic signed [CW-1:0] x, y, z, dx, dy;
			x = cx_s[k];
			y = cy_s[k];
			z = cz_s[k];
			for (int m = 0; m < CORDIC_PER; m++) begin
				dx = y >>> (k*CORDIC_PER + m);
				dy = x >>> (k*CORDIC_PER + m);
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - atan_q30(k*CORDIC_PER + m);
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + atan_q30(k*CORDIC_PER + m);
				end
			end
			nx_x[k] = x;
			nx_y[k] = y;
			nx_z[k] = z;
		end
	end

	// quadrant map and multiply by radius
	logic signed [CW-1:0] cf, sf, cabs, sabs;

	always_comb begin
		case (cq_s[CORDIC_STAGES])
			2'd0: begin
				cf = cx_s[CORDIC_STAGES];
				sf = cy_s[CORDIC_STAGES];
			end
			2'd1: begin
				cf = -cy_s[CORDIC_STAGES];
				sf = cx_s[CORDIC_STAGES];
			end
			2'd2: begin
				cf = -cx_s[CORDIC_STAGES];
				sf = -cy_s[CORDIC_STAGES];
			end
			default: begin
				cf = cy_s[CORDIC_STAGES];
				sf = -cx_s[CORDIC_STAGES];
			end
		endcase
		cabs = cf[CW-1] ? -cf : cf;
		sabs = sf[CW-1] ? -sf : sf;
	end

	logic [PROD_W-1:0] mx_s1, mz_s1;
	logic              sx_s1, sz_s1;
	tag_t              mt_s1;
	logic              m_vld_s1;

	// round, saturate and restore the sign
	function automatic logic signed [POS_W-1:0] fin_pos(input logic [PROD_W-1:0] p,
			input logic neg);
		logic [PROD_W-1:0]       v;
		logic [15:0]             v16;
		logic signed [POS_W-1:0] mag;
		v   = (p + PROD_W'(32'h2000_0000)) >> 30;
		v16 = (v > PROD_W'(POS_LIMIT)) ? POS_LIMIT : v[15:0];
		mag = $signed({1'b0, v16});
		return neg ? -mag : mag;
	endfunction

	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic [TEXU_W-1:0]       u_q;
	logic                    v_q, last_q;

	// valid bits of every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld   <= '0;
			ph_vld_s1 <= 1'b0;
			c_vld     <= '0;
			m_vld_s1  <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			div_vld   <= {div_vld[DIV_STAGES-1:0], issue};
			ph_vld_s1 <= div_vld[DIV_STAGES];
			c_vld     <= {c_vld[CORDIC_STAGES-1:0], ph_vld_s1};
			m_vld_s1  <= c_vld[CORDIC_STAGES];
			out_vld_q <= m_vld_s1;
		end
	end

	// payload of every stage
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= job;
			for (int s = 0; s < DIV_STAGES; s++) begin
				div_s[s+1] <= div_nx[s];
			end
			ph_prod_s1 <= ph_mag[29:0] * HALF_PI_Q30;
			ph_neg_s1  <= ph_neg;
			ph_quad_s1 <= ph_quad;
			ph_tag_s1  <= ph_tag;
			cx_s[0] <= GAIN_INV;
			cy_s[0] <= '0;
			cz_s[0] <= z_init;
			cq_s[0] <= ph_quad_s1;
			ct_s[0] <= ph_tag_s1;
			for (int k = 0; k < CORDIC_STAGES; k++) begin
				cx_s[k+1] <= nx_x[k];
				cy_s[k+1] <= nx_y[k];
				cz_s[k+1] <= nx_z[k];
				cq_s[k+1] <= cq_s[k];
				ct_s[k+1] <= ct_s[k];
			end
			mx_s1 <= cabs[31:0] * cfg.radius;
			mz_s1 <= sabs[31:0] * cfg.radius;
			sx_s1 <= cf[CW-1];
			sz_s1 <= sf[CW-1];
			mt_s1 <= ct_s[CORDIC_STAGES];
			px_q   <= mt_s1.apex ? '0 : fin_pos(mx_s1, sx_s1);
			pz_q   <= mt_s1.apex ? '0 : fin_pos(mz_s1, sz_s1);
			py_q   <= mt_s1.py;
			u_q    <= mt_s1.u;
			v_q    <= !mt_s1.apex;
			last_q <= mt_s1.last;
		end
	end

	assign vtx_out.valid       = out_vld_q;
	assign vtx_out.pos_x       = px_q;
	assign vtx_out.pos_y       = py_q;
	assign vtx_out.pos_z       = pz_q;
	assign vtx_out.tex_u       = u_q;
	assign vtx_out.tex_v       = v_q;
	assign vtx_out.last_vertex = last_q;

endmodule

// ===== hw/rtl/cone_segment_vertex_generator.sv =====
// Cone side tessellator: each segment word gives three vertex words (first base
// point, apex, closing base point) through the single vertex output, which moves
// one word per cycle while the receiver is ready. A new segment is taken while
// earlier ones are in flight; a 4-entry queue sits between the input and the
// vertex pipeline (8 divider stages, 8 cordic stages, scaling). Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must write it only while
// idle, as the block itself does not enforce this.
// Uses csvg_pkg, csvg_if, csvg_front, csvg_queue and csvg_back.
module cone_segment_vertex_generator import csvg_pkg::*; #(
	parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	csvg_seg_if.sink              seg_in,
	csvg_vtx_if.source            vtx_out
);

	logic [RAD_W-1:0] radius_q;
	logic [HGT_W-1:0] height_q;
	logic [SEG_W-1:0] seg_total_q;
	csvg_cfg_t        cfg;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RAD_W'(256);
			height_q    <= HGT_W'(256);
			seg_total_q <= SEG_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:   radius_q    <= cfg_data;
				REG_HEIGHT:   height_q    <= cfg_data;
				REG_SEGMENTS: seg_total_q <= cfg_data[SEG_W-1:0];
				default:      ;
			endcase
		end
	end

	// effective segment count and half height
	always_comb begin
		cfg.radius = radius_q;
		cfg.half   = ({1'b0, height_q} + 1'b1) >> 1;
		if (seg_total_q == '0) begin
			cfg.n = SEG_W'(1);
		end else if (32'(seg_total_q) > 32'(MAX_SEGMENTS)) begin
			cfg.n = SEG_W'(MAX_SEGMENTS);
		end else begin
			cfg.n = seg_total_q;
		end
	end

	logic             push, q_full, q_valid, q_pop;
	logic [IDX_W-1:0] push_idx, q_idx;

	csvg_front u_front (
		.seg_in   (seg_in),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_idx (push_idx)
	);

	csvg_queue #(
		.W     (IDX_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_idx),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_idx)
	);

	csvg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_idx   (q_idx),
		.q_pop   (q_pop),
		.vtx_out (vtx_out)
	);

endmodule

// ===== hw/rtl/csvg_checker.sv =====
// csvg_checker: port-level checks of the vertex output of the cone segment
// vertex generator, bound to the top level. Uses csvg_pkg.
module csvg_checker import csvg_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    valid,
	input logic                    ready,
	input logic signed [POS_W-1:0] pos_x,
	input logic signed [POS_W-1:0] pos_y,
	input logic signed [POS_W-1:0] pos_z,
	input logic                    tex_v,
	input logic                    last_vertex
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("vertex word dropped while stalled");

	// apex sits on the axis, never closes a segment and lies at or above zero
	a_apex: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !tex_v |-> pos_x == '0 && pos_z == '0 && !last_vertex && !pos_y[POS_W-1])
		else $error("apex word malformed");

	// closing word is a base point
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last_vertex |-> tex_v)
		else $error("closing word not on base ring");

	// base ring lies at or below zero
	a_base: assert property (@(posedge clk) disable iff (!arst_n)
		valid && tex_v |-> pos_y[POS_W-1] || pos_y == '0)
		else $error("base point above the base plane");

endmodule

bind cone_segment_vertex_generator csvg_checker u_csvg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (vtx_out.valid),
	.ready       (vtx_out.ready),
	.pos_x       (vtx_out.pos_x),
	.pos_y       (vtx_out.pos_y),
	.pos_z       (vtx_out.pos_z),
	.tex_v       (vtx_out.tex_v),
	.last_vertex (vtx_out.last_vertex)
);

// ===== test/cone_segment_vertex_generator_tb.sv =====
// cone_segment_vertex_generator_tb: drives segment words and register writes into the
// cone tessellator and checks every vertex word against a fixed-point cordic predictor.
// Depends on csvg_pkg, csvg_if and cone_segment_vertex_generator.
module cone_segment_vertex_generator_tb;
	import csvg_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int MAX_SEG = 4096;
	localparam int STEPS = 16;
	localparam longint GAIN = 652032874;
	localparam longint HALF_PI = 1686629713;

	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [TEXU_W-1:0]       u;
		logic                    v;
		logic                    last;
	} vertex_t;

	typedef struct {
		int  idx;
		bit  typed;
		int  u_open;
		int  u_close;
	} seg_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	csvg_seg_if seg_in ();
	csvg_vtx_if vtx_out ();

	cone_segment_vertex_generator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .seg_in(seg_in.sink), .vtx_out(vtx_out.source)
	);

	// shadow registers
	logic [15:0] radius_sh = 16'd256;
	logic [15:0] height_sh = 16'd256;
	logic [12:0] total_sh = 13'd16;

	vertex_t vertex_q[$];
	int errors = 0;
	bit calm = 1'b0;
	bit hold_go = 1'b0;
	int hold_left = 0;

	always #5 clk = ~clk;

	initial begin
		seg_in.valid = 1'b0;
		seg_in.segment_index = '0;
		vtx_out.ready = 1'b0;
	end

	// arctangent table, Q2.30
	function automatic longint atan_k(input int k);
		longint t[16] = '{843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
			16775850, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536,
			32768};
		return t[k];
	endfunction

	// cos and sin in Q2.30 of a phase in 2^-32 turn
	task automatic turn_sincos(input logic [31:0] p, output longint co, output longint si);
		logic [1:0] quad;
		longint r, mag, z, x, y, dx, dy;
		quad = p[31:30];
		r = longint'(p[29:0]);
		if (r >= (64'sd1 <<< 29)) begin
			r -= (64'sd1 <<< 30);
			quad = quad + 2'd1;
		end
		mag = r < 0 ? -r : r;
		mag = (mag * HALF_PI + (64'sd1 <<< 29)) >>> 30;
		z = r < 0 ? -mag : mag;
		x = GAIN;
		y = 0;
		for (int k = 0; k < STEPS; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_k(k);
			end else begin
				x += dx; y -= dy; z += atan_k(k);
			end
		end
		case (quad)
			2'd0: begin co = x; si = y; end
			2'd1: begin co = -y; si = x; end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endtask

	// trig value times radius, rounded away from zero and saturated
	function automatic logic signed [POS_W-1:0] scaled_pos(input longint trig);
		longint mag, v;
		mag = trig < 0 ? -trig : trig;
		v = (mag * longint'(radius_sh) + (64'sd1 <<< 29)) >>> 30;
		if (v > 65535)
			v = 65535;
		return POS_W'(trig < 0 ? -v : v);
	endfunction

	task automatic base_point(input longint j, input longint n, input longint half,
			input bit last, output vertex_t vt);
		longint p, co, si;
		p = ((j <<< 32) + (n >>> 1)) / n;
		turn_sincos(p[31:0], co, si);
		vt.x = scaled_pos(co);
		vt.y = POS_W'(-half);
		vt.z = scaled_pos(si);
		vt.u = TEXU_W'(((j <<< 16) + (n >>> 1)) / n);
		vt.v = 1'b1;
		vt.last = last;
	endtask

	// three vertices of one side segment under the current registers
	task automatic predict_segment(input int idx, output vertex_t vs[3]);
		longint n, i, half;
		n = total_sh;
		if (n == 0)
			n = 1;
		if (n > MAX_SEG)
			n = MAX_SEG;
		i = idx;
		if (i >= n)
			i = n - 1;
		half = (longint'(height_sh) + 1) >>> 1;
		base_point(i, n, half, 1'b0, vs[0]);
		vs[1].x = '0;
		vs[1].y = POS_W'(half);
		vs[1].z = '0;
		vs[1].u = TEXU_W'((((2 * i + 1) <<< 16) + n) / (2 * n));
		vs[1].v = 1'b0;
		vs[1].last = 1'b0;
		base_point(i + 1, n, half, 1'b1, vs[2]);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_RADIUS: radius_sh = data;
			REG_HEIGHT: height_sh = data;
			REG_SEGMENTS: total_sh = data[12:0];
			default: ;
		endcase
	endtask

	// offer one segment word, wait for the handshake, queue its vertices
	task automatic send_segment(input int idx, input bit typed, input int u_open,
			input int u_close);
		vertex_t vs[3];
		while (!calm && $urandom_range(99) < 12) begin
			seg_in.valid = 1'b0;
			@(negedge clk);
		end
		seg_in.valid = 1'b1;
		seg_in.segment_index = IDX_W'(idx);
		do @(posedge clk); while (!seg_in.ready);
		predict_segment(idx, vs);
		if (typed) begin
			vs[0].u = TEXU_W'(u_open);
			vs[2].u = TEXU_W'(u_close);
			vs[0].y = -17'sd128;
			vs[0].v = 1'b1;
			vs[2].last = 1'b1;
		end
		for (int k = 0; k < 3; k++)
			vertex_q.push_back(vs[k]);
		@(negedge clk);
		seg_in.valid = 1'b0;
	endtask

	task automatic drain;
		wait (vertex_q.size() == 0);
		repeat (30) @(negedge clk);
	endtask

	// receiver: random stalls, a quiet stretch, and one long hold-off
	always @(negedge clk) begin
		if (hold_go && hold_left == 0) begin
			hold_left = 300;
			hold_go = 1'b0;
		end
		if (hold_left > 0) begin
			vtx_out.ready = 1'b0;
			hold_left--;
		end else begin
			vtx_out.ready = calm ? 1'b1 : ($urandom_range(99) >= 12);
		end
	end

	// vertex word checker
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && vtx_out.valid && vtx_out.ready) begin
			if (vertex_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected vertex word x=%0d y=%0d z=%0d", vtx_out.pos_x,
						vtx_out.pos_y, vtx_out.pos_z);
			end else begin
				e = vertex_q.pop_front();
				if (vtx_out.pos_x !== e.x || vtx_out.pos_y !== e.y || vtx_out.pos_z !== e.z ||
						vtx_out.tex_u !== e.u || vtx_out.tex_v !== e.v ||
						vtx_out.last_vertex !== e.last) begin
					errors++;
					if (errors <= 10)
						$display("vertex mismatch exp %0d %0d %0d u=%0d v=%0b l=%0b got %0d %0d %0d u=%0d v=%0b l=%0b",
							e.x, e.y, e.z, e.u, e.v, e.last, vtx_out.pos_x, vtx_out.pos_y,
							vtx_out.pos_z, vtx_out.tex_u, vtx_out.tex_v, vtx_out.last_vertex);
				end
			end
		end
	end

	// stimulus
	initial begin
		seg_row_t rows[14] = '{
			'{0, 1, 0, 4096}, '{1, 0, 0, 0}, '{8, 1, 32768, 36864}, '{15, 1, 61440, 65536},
			'{16, 1, 61440, 65536}, '{4095, 1, 61440, 65536}, '{2048, 0, 0, 0},
			'{3, 0, 0, 0}, '{4, 0, 0, 0}, '{12, 0, 0, 0}, '{7, 0, 0, 0},
			'{2730, 0, 0, 0}, '{1365, 0, 0, 0}, '{11, 0, 0, 0}};
		int phase_r[6] = '{0, 65535, 256, 1, 4000, 32768};
		int phase_h[6] = '{0, 65535, 255, 1, 512, 65534};
		int phase_n[6] = '{0, 8191, 1, 4096, 3, 4097};
		int r, h, n, ne, idx;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[k])
			send_segment(rows[k].idx, rows[k].typed, rows[k].u_open, rows[k].u_close);
		drain();
		write_reg(REG_SPARE, 16'hFFFF);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph < 6) begin
				r = phase_r[ph]; h = phase_h[ph]; n = phase_n[ph];
			end else begin
				r = $urandom_range(65535); h = $urandom_range(65535);
				n = $urandom_range(65535);
			end
			write_reg(REG_RADIUS, 16'(r));
			write_reg(REG_HEIGHT, 16'(h));
			write_reg(REG_SEGMENTS, 16'(n));
			ne = total_sh == 0 ? 1 : (total_sh > MAX_SEG ? MAX_SEG : total_sh);
			calm = (ph == 3);
			for (int k = 0; k < 56; k++) begin
				if (ph == 5 && k == 10)
					hold_go = 1'b1;
				idx = ($urandom_range(99) < 70) ? $urandom_range(ne - 1) : $urandom_range(4095);
				send_segment(idx, 1'b0, 0, 0);
			end
			calm = 1'b0;
			drain();
		end

		repeat (40) @(negedge clk);
		if (errors == 0 && vertex_q.size() == 0)
			$display("cone_segment_vertex_generator test passed");
		else
			$display("cone_segment_vertex_generator test failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("cone_segment_vertex_generator test failed");
		$finish;
	end

endmodule
